FILE: hw/rtl/unit_staging_rotation_macros.svh
// Assertion macros for the unit staging rotation block
`ifndef UNIT_STAGING_ROTATION_MACROS_SVH
`define UNIT_STAGING_ROTATION_MACROS_SVH
`define USR_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define USR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

FILE: hw/rtl/usr_pkg.sv
// Package: types and constants for the unit staging rotation block
`default_nettype none
package usr_pkg;
   localparam int unsigned MaxUnits = 16;
   localparam int unsigned UnitWidth = 4;
   localparam int unsigned CountWidth = 5;
   localparam int unsigned MaskWidth = 8;
   localparam int unsigned CsrAddrWidth = 4;

   typedef logic [UnitWidth-1:0] unit_type;

   typedef enum logic [1:0] {
      ACT_TICK = 2'd0,
      ACT_ALARM = 2'd1,
      ACT_RUNTIME = 2'd2,
      ACT_NONE = 2'd3
   } action_type;

   typedef struct packed {
      action_type action;
      logic [3:0] goal_count;
      logic [3:0] unit;
      logic [15:0] value;
   } item_type;

   typedef struct packed {
      logic [MaskWidth-1:0] running_mask;
      logic [MaskWidth-1:0] commanded_mask;
      logic [MaskWidth-1:0] alarm_mask;
      logic [3:0] on_count;
   } result_type;

   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_FIFO = 2'd1,
      MODE_LIFO = 2'd2,
      MODE_RUNTIME = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      REG_MODE = 2'd0,
      REG_COUNT = 2'd1,
      REG_DELAY = 2'd2
   } reg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PURGE,
      ST_SORT_ON,
      ST_SORT_OFF,
      ST_WAIT_SCAN,
      ST_DECIDE,
      ST_SORT_NUM,
      ST_START,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic load;
      logic set_item;
      logic purge_step;
      logic sort_on_step;
      logic sort_off_step;
      logic sort_num_step;
      logic pass_start;
      logic pass_next;
      logic wait_step;
      logic stop_head;
      logic start_off;
      logic rotate_off;
   } cmd_type;

   typedef struct packed {
      logic purge_done;
      logic on_pass_end;
      logic off_pass_end;
      logic pass_clean;
      logic pass_last;
      logic wait_done;
      logic tick_live;
      logic want_start;
      logic want_stop;
      logic off_head_alarm;
      logic lifo;
      logic runtime_mode;
   } sts_type;
endpackage
`default_nettype wire

FILE: hw/rtl/usr_if.sv
// Valid/ready channel interface carrying one beat of payload
`default_nettype none
interface usr_if #(
   parameter type PayloadType = logic
) (
   input wire logic clock
);
   logic valid;
   logic ready;
   PayloadType payload;
   modport source(output valid, output payload, input ready);
   modport sink(input valid, input payload, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/usr_ctrl.sv
// Controller state machine sequencing one item through the datapath
`default_nettype none
module usr_ctrl (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_fire,
   input wire logic req_is_tick,
   input wire logic rsp_free,
   input wire usr_pkg::sts_type sts,
   output usr_pkg::cmd_type cmd,
   output logic req_ready,
   output logic rsp_load
);
   import usr_pkg::*;
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = 1'b0;
      rsp_load = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_fire) begin
               cmd.load = 1'b1;
               state_in = req_is_tick ? ST_PURGE : ST_RESULT;
               if (!req_is_tick) begin
                  cmd.set_item = 1'b1;
               end
            end
         end
         ST_PURGE: begin
            if (!sts.tick_live) begin
               state_in = ST_RESULT;
            end else if (sts.purge_done) begin
               cmd.pass_start = 1'b1;
               state_in = sts.runtime_mode ? ST_SORT_ON : ST_WAIT_SCAN;
            end else begin
               cmd.purge_step = 1'b1;
            end
         end
         ST_SORT_ON: begin
            if (sts.on_pass_end) begin
               if (sts.pass_clean || sts.pass_last) begin
                  cmd.pass_start = 1'b1;
                  state_in = ST_SORT_OFF;
               end else begin
                  cmd.pass_next = 1'b1;
               end
            end else begin
               cmd.sort_on_step = 1'b1;
            end
         end
         ST_SORT_OFF: begin
            if (sts.off_pass_end) begin
               if (sts.pass_clean || sts.pass_last) begin
                  cmd.pass_start = 1'b1;
                  state_in = ST_WAIT_SCAN;
               end else begin
                  cmd.pass_next = 1'b1;
               end
            end else begin
               cmd.sort_off_step = 1'b1;
            end
         end
         ST_WAIT_SCAN: begin
            if (sts.wait_done) begin
               state_in = ST_DECIDE;
            end else begin
               cmd.wait_step = 1'b1;
            end
         end
         ST_DECIDE: begin
            priority if (sts.want_start) begin
               if (sts.off_head_alarm) begin
                  cmd.rotate_off = 1'b1;
                  state_in = ST_RESULT;
               end else if (sts.lifo) begin
                  cmd.pass_start = 1'b1;
                  state_in = ST_SORT_NUM;
               end else begin
                  cmd.start_off = 1'b1;
                  state_in = ST_RESULT;
               end
            end else if (sts.want_stop) begin
               cmd.stop_head = 1'b1;
               state_in = ST_RESULT;
            end else begin
               state_in = ST_RESULT;
            end
         end
         ST_SORT_NUM: begin
            if (sts.off_pass_end) begin
               if (sts.pass_clean || sts.pass_last) begin
                  cmd.pass_start = 1'b1;
                  state_in = ST_START;
               end else begin
                  cmd.pass_next = 1'b1;
               end
            end else begin
               cmd.sort_num_step = 1'b1;
            end
         end
         ST_START: begin
            cmd.start_off = 1'b1;
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end
endmodule
`default_nettype wire

FILE: hw/rtl/usr_datapath.sv
// Datapath: unit lists, per-unit flags, run times and start delay counter
`default_nettype none
module usr_datapath #(
   parameter int unsigned UNITS = 8
) (
   input wire logic clock,
   input wire logic reset,
   input wire usr_pkg::cmd_type cmd,
   output usr_pkg::sts_type sts,
   input wire logic [1:0] req_action,
   input wire logic [3:0] req_goal_count,
   input wire logic [3:0] req_unit,
   input wire logic [15:0] req_value,
   input wire logic cfg_we,
   input wire usr_pkg::reg_type cfg_reg,
   input wire logic [31:0] cfg_data,
   output logic [1:0] mode_q,
   output logic [3:0] count_q,
   output logic [15:0] delay_q,
   output logic [7:0] running_mask,
   output logic [7:0] commanded_mask,
   output logic [7:0] alarm_mask,
   output logic [3:0] on_count
);
   import usr_pkg::*;
   localparam int unsigned IdxW = (UNITS > 1) ? $clog2(UNITS) : 1;
   localparam int unsigned LenW = $clog2(UNITS + 1);

   unit_type on_ff [UNITS];
   unit_type on_in [UNITS];
   unit_type off_ff [UNITS];
   unit_type off_in [UNITS];
   logic [LenW-1:0] on_len_ff, on_len_in, off_len_ff, off_len_in;
   logic [UNITS-1:0] cmd_ff, cmd_in, stat_ff, stat_in, alm_ff, alm_in;
   logic [15:0] rt_ff [UNITS];
   logic [15:0] dcnt_ff, dcnt_in;
   logic [1:0] mode_ff;
   logic [LenW-1:0] count_ff;
   logic [15:0] sdel_ff;
   logic [LenW-1:0] goal_ff;
   logic [LenW-1:0] pos_ff, pos_in;
   logic [LenW-1:0] pass_ff, pass_in;
   logic clean_ff, clean_in, waiting_ff, waiting_in;
   logic [3:0] set_unit;
   logic set_ok;
   logic [4:0] cfg_n;
   logic [LenW-1:0] cfg_clip;
   logic [LenW-1:0] goal_clip;
   unit_type ua, ub, uo, uh;
   logic swap;

   assign set_unit = req_unit - 4'd1;
   assign set_ok = req_unit >= 4'd1 && 5'(req_unit) <= 5'(UNITS);
   assign cfg_n = {1'b0, cfg_data[3:0]};
   assign cfg_clip = (cfg_n > 5'(UNITS)) ? LenW'(UNITS) : LenW'(cfg_n);
   assign goal_clip = (8'(req_goal_count) > 8'(count_ff)) ? count_ff
         : LenW'(req_goal_count);

   always_comb begin
      ua = '0;
      ub = '0;
      uo = '0;
      uh = off_ff[0];
      if (pos_ff < LenW'(UNITS)) begin
         uo = on_ff[pos_ff[IdxW-1:0]];
      end
      if (pos_ff + 1'b1 < LenW'(UNITS)) begin
         if (cmd.sort_on_step) begin
            ua = on_ff[pos_ff[IdxW-1:0]];
            ub = on_ff[IdxW'(pos_ff + 1'b1)];
         end else begin
            ua = off_ff[pos_ff[IdxW-1:0]];
            ub = off_ff[IdxW'(pos_ff + 1'b1)];
         end
      end
      swap = 1'b0;
      if (cmd.sort_on_step) begin
         swap = rt_ff[ua[IdxW-1:0]] < rt_ff[ub[IdxW-1:0]];
      end else if (cmd.sort_off_step) begin
         swap = rt_ff[ua[IdxW-1:0]] > rt_ff[ub[IdxW-1:0]] && !alm_ff[ub[IdxW-1:0]];
      end else if (cmd.sort_num_step) begin
         swap = ua > ub && !alm_ff[ub[IdxW-1:0]];
      end
   end

   always_comb begin
      sts = '0;
      sts.tick_live = mode_ff != MODE_IDLE;
      sts.runtime_mode = mode_ff == MODE_RUNTIME;
      sts.lifo = mode_ff == MODE_LIFO;
      sts.purge_done = pos_ff >= on_len_ff;
      sts.on_pass_end = pos_ff + LenW'(1) >= on_len_ff;
      sts.off_pass_end = pos_ff + LenW'(1) >= off_len_ff;
      sts.pass_clean = clean_ff;
      sts.pass_last = pass_ff == LenW'(UNITS - 1);
      sts.wait_done = waiting_ff || pos_ff >= on_len_ff;
      sts.want_start = !waiting_ff && on_len_ff < goal_ff && off_len_ff != '0;
      sts.want_stop = !(!waiting_ff && on_len_ff < goal_ff) && on_len_ff > goal_ff;
      sts.off_head_alarm = alm_ff[uh[IdxW-1:0]];
   end

   always_comb begin
      on_in = on_ff;
      off_in = off_ff;
      on_len_in = on_len_ff;
      off_len_in = off_len_ff;
      cmd_in = cmd_ff;
      stat_in = stat_ff;
      alm_in = alm_ff;
      dcnt_in = dcnt_ff;
      pos_in = pos_ff;
      pass_in = pass_ff;
      clean_in = clean_ff;
      waiting_in = waiting_ff;
      if (cmd.load) begin
         pos_in = '0;
         clean_in = 1'b1;
         waiting_in = 1'b0;
      end
      if (cmd.set_item && req_action == ACT_ALARM && set_ok) begin
         alm_in[set_unit[IdxW-1:0]] = req_value[0];
      end
      if (cmd.purge_step) begin
         if (alm_ff[uo[IdxW-1:0]]) begin
            cmd_in[uo[IdxW-1:0]] = 1'b0;
            stat_in[uo[IdxW-1:0]] = 1'b0;
            for (int i = 0; i < UNITS - 1; i++) begin
               if (LenW'(i) >= pos_ff) begin
                  on_in[i] = on_ff[i + 1];
               end
            end
            on_len_in = on_len_ff - 1'b1;
            if (off_len_ff < LenW'(UNITS)) begin
               off_in[off_len_ff[IdxW-1:0]] = uo;
               off_len_in = off_len_ff + 1'b1;
            end
         end else begin
            pos_in = pos_ff + 1'b1;
         end
      end
      if (cmd.sort_on_step || cmd.sort_off_step || cmd.sort_num_step) begin
         if (swap) begin
            clean_in = 1'b0;
            if (cmd.sort_on_step) begin
               on_in[pos_ff[IdxW-1:0]] = ub;
               on_in[IdxW'(pos_ff + 1'b1)] = ua;
            end else begin
               off_in[pos_ff[IdxW-1:0]] = ub;
               off_in[IdxW'(pos_ff + 1'b1)] = ua;
            end
         end
         pos_in = pos_ff + 1'b1;
      end
      if (cmd.pass_start) begin
         pos_in = '0;
         pass_in = '0;
         clean_in = 1'b1;
      end
      if (cmd.pass_next) begin
         pos_in = '0;
         pass_in = pass_ff + 1'b1;
         clean_in = 1'b1;
      end
      if (cmd.wait_step) begin
         if (cmd_ff[uo[IdxW-1:0]] && !stat_ff[uo[IdxW-1:0]]) begin
            waiting_in = 1'b1;
            dcnt_in = dcnt_ff + 16'd1;
            if (dcnt_in >= sdel_ff) begin
               dcnt_in = '0;
               stat_in[uo[IdxW-1:0]] = 1'b1;
            end
         end else begin
            pos_in = pos_ff + 1'b1;
         end
      end
      if (cmd.rotate_off) begin
         for (int i = 0; i < UNITS - 1; i++) begin
            if (LenW'(i + 1) < off_len_ff) begin
               off_in[i] = off_ff[i + 1];
            end
         end
         off_in[IdxW'(off_len_ff - 1'b1)] = uh;
      end
      if (cmd.start_off) begin
         cmd_in[uh[IdxW-1:0]] = 1'b1;
         for (int i = 0; i < UNITS - 1; i++) begin
            off_in[i] = off_ff[i + 1];
         end
         off_len_in = off_len_ff - 1'b1;
         if (mode_ff == MODE_LIFO) begin
            for (int i = 1; i < UNITS; i++) begin
               on_in[i] = on_ff[i - 1];
            end
            on_in[0] = uh;
         end else begin
            on_in[on_len_ff[IdxW-1:0]] = uh;
         end
         on_len_in = on_len_ff + 1'b1;
      end
      if (cmd.stop_head) begin
         cmd_in[on_ff[0][IdxW-1:0]] = 1'b0;
         stat_in[on_ff[0][IdxW-1:0]] = 1'b0;
         for (int i = 0; i < UNITS - 1; i++) begin
            on_in[i] = on_ff[i + 1];
         end
         on_len_in = on_len_ff - 1'b1;
         if (off_len_ff < LenW'(UNITS)) begin
            off_in[off_len_ff[IdxW-1:0]] = on_ff[0];
            off_len_in = off_len_ff + 1'b1;
         end
      end
      if (cfg_we && cfg_reg == REG_COUNT && cfg_clip != count_ff) begin
         cmd_in = '0;
         stat_in = '0;
         for (int i = 0; i < UNITS; i++) begin
            if (LenW'(i) < count_ff) begin
               alm_in[i] = 1'b0;
            end
            off_in[i] = unit_type'(i);
         end
         on_len_in = '0;
         off_len_in = cfg_clip;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         on_len_ff <= '0;
         off_len_ff <= '0;
         cmd_ff <= '0;
         stat_ff <= '0;
         alm_ff <= '0;
         dcnt_ff <= '0;
         mode_ff <= MODE_IDLE;
         count_ff <= '0;
         sdel_ff <= '0;
         pos_ff <= '0;
         pass_ff <= '0;
         clean_ff <= 1'b1;
         waiting_ff <= 1'b0;
         for (int i = 0; i < UNITS; i++) begin
            rt_ff[i] <= '0;
         end
      end else begin
         on_len_ff <= on_len_in;
         off_len_ff <= off_len_in;
         cmd_ff <= cmd_in;
         stat_ff <= stat_in;
         alm_ff <= alm_in;
         dcnt_ff <= dcnt_in;
         pos_ff <= pos_in;
         pass_ff <= pass_in;
         clean_ff <= clean_in;
         waiting_ff <= waiting_in;
         if (cfg_we && cfg_reg == REG_MODE) begin
            mode_ff <= cfg_data[1:0];
         end
         if (cfg_we && cfg_reg == REG_COUNT) begin
            count_ff <= cfg_clip;
         end
         if (cfg_we && cfg_reg == REG_DELAY) begin
            sdel_ff <= cfg_data[15:0];
         end
         if (cmd.set_item && req_action == ACT_RUNTIME && set_ok) begin
            rt_ff[set_unit[IdxW-1:0]] <= req_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      on_ff <= on_in;
      off_ff <= off_in;
      if (cmd.load) begin
         goal_ff <= goal_clip;
      end
   end

   always_comb begin
      running_mask = '0;
      commanded_mask = '0;
      alarm_mask = '0;
      for (int i = 0; i < UNITS && i < MaskWidth; i++) begin
         running_mask[i] = stat_ff[i];
         commanded_mask[i] = cmd_ff[i];
         alarm_mask[i] = alm_ff[i];
      end
   end

   assign on_count = 4'(on_len_ff);
   assign mode_q = mode_ff;
   assign count_q = 4'(count_ff);
   assign delay_q = sdel_ff;
endmodule
`default_nettype wire

FILE: hw/rtl/unit_staging_rotation.sv
// Unit staging rotation top level: channels, register port, controller and datapath
// Accepts one beat at a time and returns one result beat per item. A set or no-op item
// is accepted and then loads the result register. A tick walks the on list to drop
// alarmed units, scans it for a unit that waits on its start delay, then decides and
// loads the result; in idle mode it goes from the purge state straight to the result.
// A LIFO start adds a number sort of up to UNITS passes plus a start state; run time
// mode adds two such sorts before the scan, all bounded by the single compare-and-swap
// unit. The result register lets the next item start while a result waits; the
// controller stalls only when a second result is ready before the first beat is taken.
`default_nettype none
module unit_staging_rotation #(
   parameter int unsigned UNITS = 8
) (
   input wire logic clock,
   input wire logic reset,
   usr_if.sink req,
   usr_if.source rsp,
   input wire logic csr_psel,
   input wire logic csr_penable,
   input wire logic csr_pwrite,
   input wire logic [usr_pkg::CsrAddrWidth-1:0] csr_paddr,
   input wire logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready
);
   import usr_pkg::*;
   cmd_type cmd;
   sts_type sts;
   logic req_fire, rsp_load, rsp_valid_ff, req_ready_w;
   logic [1:0] act_ff;
   logic [3:0] goal_ff, unit_ff;
   logic [15:0] val_ff;
   logic [1:0] mode_q;
   logic [3:0] count_q;
   logic [15:0] delay_q;
   logic [7:0] run_m, cmd_m, alm_m;
   logic [3:0] on_cnt;
   logic cfg_we;
   reg_type cfg_reg;

   assign req.ready = req_ready_w;
   assign req_fire = req.valid && req_ready_w;
   assign cfg_we = csr_psel && csr_penable && csr_pwrite;
   assign cfg_reg = reg_type'(csr_paddr[3:2]);
   assign csr_pready = 1'b1;

   always_comb begin
      csr_prdata = '0;
      unique case (csr_paddr[3:2])
         REG_MODE: csr_prdata = 32'(mode_q);
         REG_COUNT: csr_prdata = 32'(count_q);
         REG_DELAY: csr_prdata = 32'(delay_q);
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         act_ff <= req.payload.action;
         goal_ff <= req.payload.goal_count;
         unit_ff <= req.payload.unit;
         val_ff <= req.payload.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp.payload.running_mask <= run_m;
         rsp.payload.commanded_mask <= cmd_m;
         rsp.payload.alarm_mask <= alm_m;
         rsp.payload.on_count <= on_cnt;
      end
   end
   assign rsp.valid = rsp_valid_ff;

   usr_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_fire(req_fire),
      .req_is_tick(req.payload.action == ACT_TICK),
      .rsp_free(!rsp_valid_ff || rsp.ready),
      .sts(sts),
      .cmd(cmd),
      .req_ready(req_ready_w),
      .rsp_load(rsp_load)
   );

   usr_datapath #(.UNITS(UNITS)) u_dp (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .sts(sts),
      .req_action(cmd.load ? req.payload.action : act_ff),
      .req_goal_count(cmd.load ? req.payload.goal_count : goal_ff),
      .req_unit(cmd.load ? req.payload.unit : unit_ff),
      .req_value(cmd.load ? req.payload.value : val_ff),
      .cfg_we(cfg_we),
      .cfg_reg(cfg_reg),
      .cfg_data(csr_pwdata),
      .mode_q(mode_q),
      .count_q(count_q),
      .delay_q(delay_q),
      .running_mask(run_m),
      .commanded_mask(cmd_m),
      .alarm_mask(alm_m),
      .on_count(on_cnt)
   );
endmodule
`default_nettype wire

FILE: hw/rtl/usr_checker.sv
// Port checker for the unit staging rotation block and its bind
`default_nettype none
`include "unit_staging_rotation_macros.svh"
module usr_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic [7:0] running_mask,
   input wire logic [7:0] commanded_mask,
   input wire logic [3:0] on_count,
   input wire logic csr_pready
);
   `USR_ASSERT_IMP(a_run_cmd, clock, reset, rsp_valid, (running_mask & ~commanded_mask) == 8'd0)
   `USR_ASSERT_IMP(a_count, clock, reset, rsp_valid, $countones(commanded_mask) <= 32'(on_count))
   `USR_ASSERT_NEXT(a_one_item, clock, reset, req_valid && req_ready, !req_ready)
   `USR_ASSERT_IMP(a_pready, clock, reset, 1'b1, csr_pready)
   `USR_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
endmodule

bind unit_staging_rotation usr_checker u_chk (
   .clock(clock),
   .reset(reset),
   .req_valid(req.valid),
   .req_ready(req.ready),
   .rsp_valid(rsp.valid),
   .rsp_ready(rsp.ready),
   .running_mask(rsp.payload.running_mask),
   .commanded_mask(rsp.payload.commanded_mask),
   .on_count(rsp.payload.on_count),
   .csr_pready(csr_pready)
);
`default_nettype wire
